@@ rtl/core/tspz_pkg.sv @@
// Shared types, register indexes and saturation helpers for the trapezoid shaper.
package tspz_pkg;

  typedef enum logic [1:0] {
    REG_RISE_TIME = 2'd0,
    REG_GAP_TIME  = 2'd1,
    REG_PZ_GAIN   = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  localparam int SAMPLE_W = 16;
  localparam int TRAP_W   = 32;
  localparam int SUM_W    = 48;
  localparam int PZ_W     = 40;
  localparam int GAIN_W   = 24;
  localparam int TIME_W   = 11;
  localparam int CFG_W    = 24;

  localparam logic [TIME_W-1:0] RISE_RESET = 11'd400;
  localparam logic [TIME_W-1:0] GAP_RESET  = 11'd50;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd3355;

  typedef logic signed [TRAP_W-1:0] trap_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PZ_W-1:0]   pz_t;

  function automatic trap_t sat_trap(input logic signed [TRAP_W+1:0] v);
    if (v[TRAP_W+1:TRAP_W-1] == 3'b000 || v[TRAP_W+1:TRAP_W-1] == 3'b111) begin
      return v[TRAP_W-1:0];
    end
    return v[TRAP_W+1] ? {1'b1, {(TRAP_W-1){1'b0}}} : {1'b0, {(TRAP_W-1){1'b1}}};
  endfunction

  function automatic sum_t sat_sum(input logic signed [SUM_W:0] v);
    if (v[SUM_W] == v[SUM_W-1]) begin
      return v[SUM_W-1:0];
    end
    return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
  endfunction

  function automatic pz_t sat_pz(input logic signed [49:0] v);
    if (v[49:PZ_W-1] == '0 || v[49:PZ_W-1] == '1) begin
      return v[PZ_W-1:0];
    end
    return v[49] ? {1'b1, {(PZ_W-1){1'b0}}} : {1'b0, {(PZ_W-1){1'b1}}};
  endfunction

endpackage

@@ rtl/core/trapezoid_shaper_pole_zero.sv @@
// Trapezoidal shaping filter with a single pole-zero correction stage.
// One signed 16-bit sample enters per beat on the in_ channel; each sample gives
// one result beat on the out_ channel carrying the trapezoid value and the
// pole-zero corrected value, in input order.
// Registers are written through the cfg_ channel (index 0 rise time, 1 gap time,
// 2 pole-zero gain); cfg_ready is always high. Writes are to be made by the user only
// while idle; the block itself does not enforce it. Throughput is one sample per cycle
// while in_ready is high (no stalled result, no offset reduction): two copies of the
// delay line, written once per accepted sample and read at the three trapezoid taps,
// and a six-stage datapath set that rate. After reset, and after a rise or gap write,
// in_ready stays low while the tap offsets are reduced modulo the delay depth, one
// subtraction of the depth per cycle.
// The first 2M+K+1 samples after reset give zero results and leave the
// accumulators untouched. When out_ready is low with a result waiting, the whole
// datapath holds and in_ready drops until the result is taken.
module trapezoid_shaper_pole_zero #(
  parameter int MAX_RISE    = 1024,
  parameter int MAX_GAP     = 1024,
  parameter int DELAY_DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tspz_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tspz_pkg::TRAP_W-1:0]     out_trap_out,
  output logic signed [tspz_pkg::PZ_W-1:0]       out_pz_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [tspz_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = $clog2(2 * MAX_RISE + MAX_GAP + 2);
  localparam int EW = (SW > tspz_pkg::TIME_W) ? SW : tspz_pkg::TIME_W;
  localparam int RW = (SW > AW + 1) ? SW : AW + 1;
  localparam logic [AW:0] DEPTH_A = (AW + 1)'(DELAY_DEPTH);
  localparam logic [RW-1:0] DEPTH_R = RW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(DELAY_DEPTH - 1);

  logic [tspz_pkg::TIME_W-1:0] rise_time_r;
  logic [tspz_pkg::TIME_W-1:0] gap_time_r;
  logic [tspz_pkg::GAIN_W-1:0] pz_gain_r;
  logic                        reload_r;

  logic [EW-1:0] rise_ext;
  logic [EW-1:0] gap_ext;
  logic [EW-1:0] m_clamp;
  logic [EW-1:0] k_clamp;
  logic [SW-1:0] m_len;
  logic [SW-1:0] k_len;

  logic [SW-1:0] span_r;
  logic [RW-1:0] m_mod_r;
  logic [RW-1:0] mk_mod_r;
  logic [RW-1:0] sp_mod_r;
  logic          busy;

  logic          adv;
  logic          in_fire;
  logic          act0;
  logic [AW-1:0] wp_r;
  logic [SW-1:0] seen_r;
  logic [AW:0]   ma_diff;
  logic [AW:0]   ma_wrap;
  logic [AW-1:0] ma;
  logic [AW:0]   xa_diff;
  logic [AW:0]   xa_wrap;
  logic [AW-1:0] xa;
  logic [AW:0]   sa_diff;
  logic [AW:0]   sa_wrap;
  logic [AW-1:0] sa;

  logic signed [tspz_pkg::SAMPLE_W-1:0] x_mem [DELAY_DEPTH];
  logic signed [tspz_pkg::SAMPLE_W-1:0] t_mem [DELAY_DEPTH];

  logic                                 v1_r;
  logic                                 act1_r;
  logic                                 fwdm1_r;
  logic                                 fwdk1_r;
  logic                                 fwds1_r;
  logic signed [tspz_pkg::SAMPLE_W-1:0] x1_r;
  logic signed [tspz_pkg::SAMPLE_W-1:0] rdm_r;
  logic signed [tspz_pkg::SAMPLE_W-1:0] rdk_r;
  logic signed [tspz_pkg::SAMPLE_W-1:0] rds_r;
  logic signed [tspz_pkg::SAMPLE_W-1:0] xm1;
  logic signed [tspz_pkg::SAMPLE_W-1:0] xk1;
  logic signed [tspz_pkg::SAMPLE_W-1:0] xs1;
  logic signed [tspz_pkg::SAMPLE_W+1:0] d1;

  logic                                 v2_r;
  logic                                 act2_r;
  logic signed [tspz_pkg::SAMPLE_W+1:0] d2_r;
  tspz_pkg::trap_t                      acc_r;
  tspz_pkg::trap_t                      acc_nxt;

  logic                                 v3_r;
  logic                                 act3_r;
  tspz_pkg::trap_t                      trap3_r;
  tspz_pkg::sum_t                       sum_r;
  tspz_pkg::sum_t                       sum_nxt;

  logic                                 v4_r;
  logic                                 act4_r;
  tspz_pkg::trap_t                      trap4_r;
  tspz_pkg::sum_t                       sum4_r;

  logic                                 v5_r;
  logic                                 act5_r;
  tspz_pkg::trap_t                      trap5_r;
  logic signed [48:0]                   ph5_r;
  logic [47:0]                          pl5_r;
  logic signed [49:0]                   pz_raw;

  logic                                 out_valid_r;
  tspz_pkg::trap_t                      out_trap_r;
  tspz_pkg::pz_t                        out_pz_r;

  // Configuration registers and tap offset reduction.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_time_r <= tspz_pkg::RISE_RESET;
      gap_time_r  <= tspz_pkg::GAP_RESET;
      pz_gain_r   <= tspz_pkg::GAIN_RESET;
      reload_r    <= 1'b1;
    end else begin
      reload_r <= 1'b0;
      if (cfg_valid) begin
        unique case (tspz_pkg::cfg_reg_t'(cfg_index))
          tspz_pkg::REG_RISE_TIME: begin
            rise_time_r <= cfg_wdata[tspz_pkg::TIME_W-1:0];
            reload_r    <= 1'b1;
          end
          tspz_pkg::REG_GAP_TIME: begin
            gap_time_r <= cfg_wdata[tspz_pkg::TIME_W-1:0];
            reload_r   <= 1'b1;
          end
          tspz_pkg::REG_PZ_GAIN: begin
            pz_gain_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign rise_ext = EW'(rise_time_r);
  assign gap_ext  = EW'(gap_time_r);

  always_comb begin
    if (rise_ext == '0) begin
      m_clamp = EW'(1);
    end else if (rise_ext > EW'(MAX_RISE)) begin
      m_clamp = EW'(MAX_RISE);
    end else begin
      m_clamp = rise_ext;
    end
    if (gap_ext > EW'(MAX_GAP)) begin
      k_clamp = EW'(MAX_GAP);
    end else begin
      k_clamp = gap_ext;
    end
  end

  assign m_len = m_clamp[SW-1:0];
  assign k_len = k_clamp[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= '0;
      m_mod_r  <= '0;
      mk_mod_r <= '0;
      sp_mod_r <= '0;
    end else if (reload_r) begin
      span_r   <= SW'({m_len, 1'b0}) + k_len;
      m_mod_r  <= RW'(m_len);
      mk_mod_r <= RW'(m_len) + RW'(k_len);
      sp_mod_r <= RW'({m_len, 1'b0}) + RW'(k_len);
    end else begin
      if (m_mod_r >= DEPTH_R) begin
        m_mod_r <= m_mod_r - DEPTH_R;
      end
      if (mk_mod_r >= DEPTH_R) begin
        mk_mod_r <= mk_mod_r - DEPTH_R;
      end
      if (sp_mod_r >= DEPTH_R) begin
        sp_mod_r <= sp_mod_r - DEPTH_R;
      end
    end
  end

  assign busy = reload_r || (m_mod_r >= DEPTH_R) || (mk_mod_r >= DEPTH_R)
                || (sp_mod_r >= DEPTH_R);

  // Handshake: the whole datapath advances unless a result waits on a stalled receiver.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !busy;
  assign in_fire  = in_valid && in_ready;
  assign act0     = seen_r > span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      seen_r <= '0;
    end else if (in_fire) begin
      wp_r <= (wp_r == LAST_A) ? '0 : wp_r + 1'b1;
      if (!act0) begin
        seen_r <= seen_r + 1'b1;
      end
    end
  end

  // Stage 0: write the sample and read x[n-M], x[n-M-K] and x[n-2M-K].
  assign ma_diff = {1'b0, wp_r} - {1'b0, m_mod_r[AW-1:0]};
  assign ma_wrap = ma_diff + DEPTH_A;
  assign ma      = ma_diff[AW] ? ma_wrap[AW-1:0] : ma_diff[AW-1:0];

  assign xa_diff = {1'b0, wp_r} - {1'b0, mk_mod_r[AW-1:0]};
  assign xa_wrap = xa_diff + DEPTH_A;
  assign xa      = xa_diff[AW] ? xa_wrap[AW-1:0] : xa_diff[AW-1:0];

  assign sa_diff = {1'b0, wp_r} - {1'b0, sp_mod_r[AW-1:0]};
  assign sa_wrap = sa_diff + DEPTH_A;
  assign sa      = sa_diff[AW] ? sa_wrap[AW-1:0] : sa_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_mem[wp_r] <= in_sample;
      t_mem[wp_r] <= in_sample;
    end
    if (adv) begin
      rdm_r   <= x_mem[ma];
      rdk_r   <= x_mem[xa];
      rds_r   <= t_mem[sa];
      x1_r    <= in_sample;
      act1_r  <= act0;
      fwdm1_r <= (m_mod_r[AW-1:0] == '0);
      fwdk1_r <= (mk_mod_r[AW-1:0] == '0);
      fwds1_r <= (sp_mod_r[AW-1:0] == '0);
    end
  end

  // Stage 1: d[n] = x[n] - x[n-M] - x[n-M-K] + x[n-2M-K].
  assign xm1 = fwdm1_r ? x1_r : rdm_r;
  assign xk1 = fwdk1_r ? x1_r : rdk_r;
  assign xs1 = fwds1_r ? x1_r : rds_r;
  assign d1  = (tspz_pkg::SAMPLE_W + 2)'(x1_r) - (tspz_pkg::SAMPLE_W + 2)'(xm1)
               - (tspz_pkg::SAMPLE_W + 2)'(xk1) + (tspz_pkg::SAMPLE_W + 2)'(xs1);

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r   <= d1;
      act2_r <= act1_r;
    end
  end

  // Stage 2: trapezoid accumulator.
  assign acc_nxt = tspz_pkg::sat_trap((tspz_pkg::TRAP_W + 2)'(acc_r)
                                      + (tspz_pkg::TRAP_W + 2)'(d2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && v2_r && act2_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act3_r  <= act2_r;
      trap3_r <= act2_r ? acc_nxt : '0;
    end
  end

  // Stage 3: running sum of trapezoid values.
  assign sum_nxt = tspz_pkg::sat_sum((tspz_pkg::SUM_W + 1)'(sum_r)
                                     + (tspz_pkg::SUM_W + 1)'(trap3_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (adv && v3_r && act3_r) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act4_r  <= act3_r;
      trap4_r <= trap3_r;
      sum4_r  <= sum_nxt;
    end
  end

  // Stage 4: gain product split into high and low halves of the sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      act5_r  <= act4_r;
      trap5_r <= trap4_r;
      ph5_r   <= 49'($signed(sum4_r[47:24]) * $signed({1'b0, pz_gain_r}));
      pl5_r   <= sum4_r[23:0] * pz_gain_r;
    end
  end

  // Stage 5: floored gain product plus trapezoid, saturated to the output width.
  assign pz_raw = 50'(ph5_r) + 50'($signed({1'b0, pl5_r[47:24]})) + 50'(trap5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_trap_r <= trap5_r;
      out_pz_r   <= act5_r ? tspz_pkg::sat_pz(pz_raw) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_trap_out = out_trap_r;
  assign out_pz_out   = out_pz_r;

endmodule
